FILE: rtl/core/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the RTC drift calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  localparam int unsigned CLK_HZ      = 48000000;
  localparam int unsigned DIVA_FRAC_W = 14;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LP_CYCLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERR   = 2'd2;

  // result action codes
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_STARTED   = 3'd1;
  localparam logic [2:0] ACT_SET       = 3'd2;
  localparam logic [2:0] ACT_SET_RECFG = 3'd3;
  localparam logic [2:0] ACT_ERR_RESET = 3'd4;
  localparam logic [2:0] ACT_CLEARED   = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [30:0] rtc_seconds;
    logic [7:0]  rtc_subsec;
    logic [23:0] avg_cycles;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        set_seconds;
    logic [17:0]        prescaler_int;
    logic [13:0]        prescaler_frac;
    logic signed [31:0] error_total;
  } out_item_t;

  // divider operand select
  typedef enum logic [1:0] {
    DV_Q   = 2'd0,
    DV_RD  = 2'd1,
    DV_PRE = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     cap_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul_start;
    logic     mul_sel_r;
    logic     ld_now;
    logic     ld_delta;
    logic     ld_q;
    logic     ld_qd;
    logic     ld_rd;
    logic     ld_sum;
    logic     do_clear;
    logic     do_start;
    logic     do_decide;
    logic     ld_presc;
    logic     ld_out;
  } rdc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic mode;
    logic ref_zero;
    logic need_reconf;
  } rdc_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/rtc_drift_calibrator.sv
// ----------------------------------------------------------------------------
// rtc_drift_calibrator
// Tracks RTC drift against a measured 48 MHz cycle count and issues time
// corrections and prescaler updates.
// ----------------------------------------------------------------------------
//  channel | ports                        | handshake
//  --------+------------------------------+------------------------
//  input   | in_valid/in_ready/in_data    | transfer on valid & ready
//  result  | out_valid/out_ready/out_data | transfer on valid & ready
//  config  | cfg_we/cfg_idx/cfg_wdata     | write on cfg_we, no wait
//
//  One item at a time. Between the input transfer and the load of the result,
//  a clear only captures the item, forms the time and branches; a start runs
//  one serial divide for the prescaler; an ordinary tick runs two divides and
//  two multiplies, and a prescaler update adds one more divide. Subsecond
//  scaling is a constant table. The shared serial divider sets the rate.
//  Reset is synchronous; a finished result waits in the output register
//  while the next item is taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_drift_calibrator #(
  parameter int unsigned SUBSEC_DIV = 256,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // calibration ticks and time-set events
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rdc_pkg::in_item_t              in_data,
  // results
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rdc_pkg::out_item_t                  out_data
);

  rdc_pkg::rdc_cmd_t cmd;
  rdc_pkg::rdc_sts_t sts;

  // sequencer: one state per datapath step, waits on unit done flags
  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, calibration state and result register
  rdc_datapath #(
    .SUBSEC_DIV (SUBSEC_DIV),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rdc_div.sv
// ----------------------------------------------------------------------------
// rdc_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [34:0] divisor,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [34:0]      remainder
);

  logic [63:0] dvd_r, dvd_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [34:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [35:0] rem_sh;
  logic        ge;

  assign rem_sh  = {rem_r, dvd_r[63]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_nxt = ge ? 35'(rem_sh - {1'b0, dvs_r}) : rem_sh[34:0];
  assign dvd_nxt = {dvd_r[62:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: rtl/core/rdc_mul.sv
// ----------------------------------------------------------------------------
// rdc_mul
// Shift-add multiplier, 64 x 24 bits, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [23:0] b,
  output logic             done,
  output logic [87:0]      prod
);

  logic [87:0] mcand_r, acc_r;
  logic [23:0] mplier_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd23) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= 88'(a);
      mplier_r <= b;
      acc_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[86:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[23:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

FILE: rtl/core/rdc_datapath.sv
// ----------------------------------------------------------------------------
// rdc_datapath
// Calibration state, configuration registers, arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_datapath #(
  parameter int unsigned SUBSEC_DIV = 256,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rdc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [rdc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire rdc_pkg::in_item_t                 in_data,
  input  wire rdc_pkg::rdc_cmd_t                 cmd,
  output rdc_pkg::rdc_sts_t                      sts,
  output rdc_pkg::out_item_t                     out_data
);

  localparam logic signed [63:0] DRIFT_CAP = 64'sd1 <<< 62;

  // configuration
  logic [7:0]  lp_r;
  logic [23:0] fallback_r;
  logic [6:0]  max_r;

  // calibration state
  logic [23:0]        ref_r;
  logic signed [63:0] start_r, err_r;

  // per-item working registers
  rdc_pkg::in_item_t  in_r;
  logic signed [63:0] now_r, s_r;
  logic [63:0]        m_r, q_r;
  logic [23:0]        d_r, r_r;
  logic               neg_r;
  logic [87:0]        qd_r;
  logic [47:0]        rd_r;
  logic [2:0]         action_r;
  logic [31:0]        set_r, presc_r;
  logic               reconf_r;
  rdc_pkg::out_item_t out_r;

  // units
  logic [63:0] div_dvd, div_q;
  logic [34:0] div_dvs, div_rem;
  logic        div_done, mul_done;
  logic [87:0] mul_p;
  logic [63:0] mul_a;

  // subsecond count scaled to FRAC_BITS fraction bits, one entry per count
  logic [63:0] sub_frac [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_sub_frac
    assign sub_frac[gi] = (64'(gi) << FRAC_BITS) / 64'(SUBSEC_DIV);
  end

  rdc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign mul_a = cmd.mul_sel_r ? 64'(r_r) : q_r;

  rdc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (d_r),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // prescaler operands
  logic [23:0] v;
  logic [33:0] num_base;
  logic [47:0] num;
  logic [34:0] pdiv;

  assign v        = (in_r.avg_cycles != '0) ? in_r.avg_cycles : fallback_r;
  assign num_base = 34'(rdc_pkg::CLK_HZ) * 34'(lp_r);
  assign num      = {num_base, {rdc_pkg::DIVA_FRAC_W{1'b0}}};
  assign pdiv     = 35'(v) * 35'(SUBSEC_DIV);

  always_comb begin
    case (cmd.div_sel)
      rdc_pkg::DV_Q: begin
        div_dvd = m_r;
        div_dvs = 35'(ref_r);
      end
      rdc_pkg::DV_RD: begin
        div_dvd = 64'(rd_r);
        div_dvs = 35'(ref_r);
      end
      default: begin
        div_dvd = 64'(num) + 64'(pdiv >> 1);
        div_dvs = pdiv;
      end
    endcase
  end

  // drift and error terms
  logic signed [63:0] delta, drift, s_sum, one_fx, lim_fx, cal, base;
  logic [63:0]        mag, mag_sum, whole;
  logic               avg_lt, over_lim, over_one, d_gt_half;

  assign delta   = now_r - start_r;
  assign avg_lt  = in_r.avg_cycles < ref_r;
  assign mag_sum = 64'(qd_r) + div_q;

  always_comb begin
    if (qd_r > 88'(DRIFT_CAP)) begin
      mag = 64'(DRIFT_CAP);
    end else if (mag_sum > 64'(DRIFT_CAP)) begin
      mag = 64'(DRIFT_CAP);
    end else begin
      mag = mag_sum;
    end
  end

  assign drift     = neg_r ? -$signed(mag) : $signed(mag);
  assign s_sum     = err_r + drift;
  assign one_fx    = 64'sd1 <<< FRAC_BITS;
  assign lim_fx    = $signed(64'(max_r) << FRAC_BITS);
  assign over_lim  = (s_r > lim_fx) || (s_r < -lim_fx);
  assign over_one  = (s_r > one_fx) || (s_r < -one_fx);
  assign d_gt_half = d_r > 24'(lp_r >> 1);
  assign cal       = now_r + s_r;
  assign whole     = cal[63] ? 64'd0 : (64'(cal) >> FRAC_BITS);
  assign base      = $signed(whole << FRAC_BITS);

  assign sts.div_done    = div_done;
  assign sts.mul_done    = mul_done;
  assign sts.mode        = in_r.mode;
  assign sts.ref_zero    = ref_r == '0;
  assign sts.need_reconf = !over_lim && over_one && d_gt_half;

  // configuration and calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r       <= 8'd8;
      fallback_r <= 24'd1200000;
      max_r      <= 7'd60;
      ref_r      <= '0;
      start_r    <= '0;
      err_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          rdc_pkg::CFG_LP_CYCLES: lp_r       <= cfg_wdata[7:0];
          rdc_pkg::CFG_FALLBACK:  fallback_r <= cfg_wdata;
          rdc_pkg::CFG_MAX_ERR:   max_r      <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (cmd.do_clear) begin
        ref_r   <= '0;
        start_r <= '0;
        err_r   <= '0;
      end
      if (cmd.do_start) begin
        ref_r   <= v;
        start_r <= now_r;
        err_r   <= '0;
      end
      if (cmd.do_decide) begin
        if (over_lim) begin
          ref_r   <= '0;
          start_r <= '0;
          err_r   <= '0;
        end else if (over_one) begin
          err_r   <= cal - base;
          start_r <= base;
          if (d_gt_half) begin
            ref_r <= v;
          end
        end else begin
          err_r   <= s_r;
          start_r <= now_r;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r     <= in_data;
      action_r <= rdc_pkg::ACT_NONE;
      set_r    <= '0;
      reconf_r <= 1'b0;
    end
    if (cmd.ld_now) begin
      now_r <= $signed((64'(in_r.rtc_seconds) << FRAC_BITS) + sub_frac[in_r.rtc_subsec]);
    end
    if (cmd.ld_delta) begin
      m_r   <= delta[63] ? 64'(-delta) : 64'(delta);
      d_r   <= avg_lt ? (ref_r - in_r.avg_cycles) : (in_r.avg_cycles - ref_r);
      neg_r <= delta[63] ^ avg_lt;
    end
    if (cmd.ld_q) begin
      q_r <= div_q;
      // remainder is below ref_r
      r_r <= 24'(div_rem);
    end
    if (cmd.ld_qd) begin
      qd_r <= mul_p;
    end
    if (cmd.ld_rd) begin
      rd_r <= mul_p[47:0];
    end
    if (cmd.ld_sum) begin
      s_r <= s_sum;
    end
    if (cmd.do_clear) begin
      action_r <= rdc_pkg::ACT_CLEARED;
    end
    if (cmd.do_start) begin
      action_r <= rdc_pkg::ACT_STARTED;
      reconf_r <= 1'b1;
    end
    if (cmd.do_decide) begin
      if (over_lim) begin
        action_r <= rdc_pkg::ACT_ERR_RESET;
      end else if (over_one) begin
        set_r <= whole[31:0];
        if (d_gt_half) begin
          action_r <= rdc_pkg::ACT_SET_RECFG;
          reconf_r <= 1'b1;
        end else begin
          action_r <= rdc_pkg::ACT_SET;
        end
      end else begin
        action_r <= rdc_pkg::ACT_NONE;
      end
    end
    if (cmd.ld_presc) begin
      if (pdiv == '0 || div_q > 64'hFFFF_FFFF) begin
        presc_r <= 32'hFFFF_FFFF;
      end else begin
        presc_r <= div_q[31:0];
      end
    end
    if (cmd.ld_out) begin
      out_r.action         <= action_r;
      out_r.set_seconds    <= set_r;
      out_r.prescaler_int  <= reconf_r ? presc_r[31:14] : '0;
      out_r.prescaler_frac <= reconf_r ? presc_r[13:0] : '0;
      if (err_r > 64'sd2147483647) begin
        out_r.error_total <= 32'sh7FFF_FFFF;
      end else if (err_r < -64'sd2147483648) begin
        out_r.error_total <= 32'sh8000_0000;
      end else begin
        out_r.error_total <= err_r[31:0];
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

FILE: rtl/core/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: steps one item through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire rdc_pkg::rdc_sts_t  sts,
  output rdc_pkg::rdc_cmd_t       cmd
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_TIME    = 15'h0002,
    S_BRANCH  = 15'h0004,
    S_QDIV    = 15'h0008,
    S_QDIV_W  = 15'h0010,
    S_MULQ    = 15'h0020,
    S_MULQ_W  = 15'h0040,
    S_MULR    = 15'h0080,
    S_MULR_W  = 15'h0100,
    S_RDIV    = 15'h0200,
    S_RDIV_W  = 15'h0400,
    S_DECIDE  = 15'h0800,
    S_PRE     = 15'h1000,
    S_PRE_W   = 15'h2000,
    S_OUT     = 15'h4000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = rdc_pkg::DV_Q;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_TIME;
        end
      end
      S_TIME: begin
        cmd.ld_now = 1'b1;
        state_nxt  = S_BRANCH;
      end
      S_BRANCH: begin
        if (sts.mode) begin
          cmd.do_clear = 1'b1;
          state_nxt    = S_OUT;
        end else if (sts.ref_zero) begin
          cmd.do_start = 1'b1;
          state_nxt    = S_PRE;
        end else begin
          cmd.ld_delta = 1'b1;
          state_nxt    = S_QDIV;
        end
      end
      S_QDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rdc_pkg::DV_Q;
        state_nxt     = S_QDIV_W;
      end
      S_QDIV_W: begin
        cmd.div_sel = rdc_pkg::DV_Q;
        if (sts.div_done) begin
          cmd.ld_q  = 1'b1;
          state_nxt = S_MULQ;
        end
      end
      S_MULQ: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MULQ_W;
      end
      S_MULQ_W: begin
        if (sts.mul_done) begin
          cmd.ld_qd = 1'b1;
          state_nxt = S_MULR;
        end
      end
      S_MULR: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel_r = 1'b1;
        state_nxt     = S_MULR_W;
      end
      S_MULR_W: begin
        cmd.mul_sel_r = 1'b1;
        if (sts.mul_done) begin
          cmd.ld_rd = 1'b1;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rdc_pkg::DV_RD;
        state_nxt     = S_RDIV_W;
      end
      S_RDIV_W: begin
        cmd.div_sel = rdc_pkg::DV_RD;
        if (sts.div_done) begin
          cmd.ld_sum = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.do_decide = 1'b1;
        state_nxt     = sts.need_reconf ? S_PRE : S_OUT;
      end
      S_PRE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rdc_pkg::DV_PRE;
        state_nxt     = S_PRE_W;
      end
      S_PRE_W: begin
        cmd.div_sel = rdc_pkg::DV_PRE;
        if (sts.div_done) begin
          cmd.ld_presc = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks for the RTC drift calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rdc_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.action <= rdc_pkg::ACT_CLEARED)
    else $error("undefined action code");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.action == rdc_pkg::ACT_NONE ||
                  out_data.action == rdc_pkg::ACT_CLEARED ||
                  out_data.action == rdc_pkg::ACT_ERR_RESET)
    |-> out_data.set_seconds == '0 && out_data.prescaler_int == '0 &&
        out_data.prescaler_frac == '0)
    else $error("fields set for an action that carries none");

endmodule

bind rtc_drift_calibrator rdc_checker u_rdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
